// ===== hw/rtl/bes_pkg.sv =====
package bes_pkg;

  localparam int MaxPoints = 64;
  localparam int SlotW     = 6;
  localparam int TimeW     = 48;
  localparam int ValW      = 32;
  localparam int QW        = 41;   // quotient magnitude, held once it reaches 2^40
  localparam int DivSteps  = 81;   // product bits (32 + 49)

  localparam logic [TimeW-1:0] TimeStepReset = 48'd97391;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_SAMPLE   = 2'd0,
    ST_START_OK = 2'd1,
    ST_START_NG = 2'd2,
    ST_NO_START = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    CFG_TIME_STEP   = 1'b0,
    CFG_POINT_COUNT = 1'b1
  } cfg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_MUL2,
    S_DIV,
    S_DONE
  } fsm_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [5:0]        point_index;
    logic [47:0]       point_time;
    logic signed [31:0] point_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic               finished;
    logic [1:0]         status;
  } out_item_t;

endpackage

// ===== hw/rtl/breakpoint_envelope_stream_unit.sv =====
// channel   dir  handshake                 payload
// item in   in   start & !busy             item_i (bes_pkg::in_item_t)
// result    out  result_valid_o (1 cycle)  result_o (bes_pkg::out_item_t)
// config    in   cfg_valid_i & cfg_ready_o cfg_index_i, cfg_data_i
//
// Write items never raise busy; a start holds busy through DONE only, a tick before
// start or a finished tick through READ and DONE. An interpolating tick reads both
// span points (READ), forms the 32x49 product as a low 32x32 and a high 32x17 part
// (MUL, MUL2) and runs a restoring divider one bit a cycle (DIV); the divider sets
// the rate. Each result shows in the same cycle that busy drops.
// Reset clears position and stream state; the table holds garbage until written.
// The receiver cannot stall: each result shows for one cycle only.
module breakpoint_envelope_stream_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  bes_pkg::in_item_t    item_i,
  output logic                 result_valid_o,
  output bes_pkg::out_item_t   result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [47:0]          cfg_data_i
);

  // table memories: two ports each by keeping two copies
  logic [47:0]        mem_t_a [bes_pkg::MaxPoints];
  logic [47:0]        mem_t_b [bes_pkg::MaxPoints];
  logic signed [31:0] mem_v_a [bes_pkg::MaxPoints];
  logic signed [31:0] mem_v_b [bes_pkg::MaxPoints];

  logic [47:0] time_step_q;
  logic [6:0]  point_count_q;
  logic [47:0] pos_q, pos_d;
  logic [5:0]  left_q, left_d;
  logic        more_q, more_d, started_q, started_d;

  bes_pkg::fsm_e state_q, state_d;
  bes_pkg::in_item_t item_q;

  logic [47:0]        lt_q, rt_q;
  logic signed [31:0] lv_q, rv_q;
  logic [5:0] rslot;
  logic [6:0] eff_cnt;
  logic [48:0] next_pos;

  logic [bes_pkg::DivSteps-1:0] prod_q;
  logic [48:0]   den_q, rem_q;
  logic [bes_pkg::QW-1:0] quo_q;
  logic [6:0]    cnt_q;
  logic          neg_q, zero_q, wzero_q;

  logic               rv_d;
  bes_pkg::out_item_t res_d, res_q;
  logic               res_v_q;

  assign busy        = (state_q != bes_pkg::S_IDLE);
  assign cfg_ready_o = (state_q == bes_pkg::S_IDLE);
  assign rslot   = (left_q == 6'(bes_pkg::MaxPoints - 1)) ? 6'(bes_pkg::MaxPoints - 1)
                                                          : left_q + 6'd1;
  assign eff_cnt = (point_count_q > 7'(bes_pkg::MaxPoints)) ? 7'(bes_pkg::MaxPoints)
                                                           : point_count_q;
  assign next_pos = {1'b0, pos_q} + {1'b0, time_step_q};

  // table write and registered reads
  always_ff @(posedge clk_i) begin
    if (start && !busy && item_i.cmd == bes_pkg::CMD_WRITE) begin
      mem_t_a[item_i.point_index] <= item_i.point_time;
      mem_t_b[item_i.point_index] <= item_i.point_time;
      mem_v_a[item_i.point_index] <= item_i.point_value;
      mem_v_b[item_i.point_index] <= item_i.point_value;
    end
    lt_q <= mem_t_a[left_q];
    lv_q <= mem_v_a[left_q];
    rt_q <= mem_t_b[rslot];
    rv_q <= mem_v_b[rslot];
  end

  // span arithmetic from the read data
  logic signed [49:0] width_s, diff_s;
  logic signed [33:0] height_s;
  logic [48:0] wmag, dmag;
  logic [31:0] hmag;
  always_comb begin
    width_s  = $signed({2'b00, rt_q}) - $signed({2'b00, lt_q});
    diff_s   = $signed({2'b00, pos_q}) - $signed({2'b00, lt_q});
    height_s = $signed({{2{rv_q[31]}}, rv_q}) - $signed({{2{lv_q[31]}}, lv_q});
    wmag = width_s[49]  ? 49'(-width_s)  : width_s[48:0];
    dmag = diff_s[49]   ? 49'(-diff_s)   : diff_s[48:0];
    hmag = height_s[33] ? 32'(-height_s) : height_s[31:0];
  end

  // product halves: low 32x32, high 32x17
  logic [63:0] mul_lo;
  logic [48:0] mul_hi;
  always_comb begin
    mul_lo = {32'd0, hmag} * {32'd0, dmag[31:0]};
    mul_hi = {17'd0, hmag} * {32'd0, dmag[48:32]};
  end

  // divider step
  logic [49:0] rem_sh;
  logic        ge;
  always_comb begin
    rem_sh = {rem_q, prod_q[bes_pkg::DivSteps-1]};
    ge     = rem_sh >= {1'b0, den_q};
  end

  // final value
  logic signed [42:0] sum;
  always_comb begin
    sum = neg_q ? $signed({{11{lv_q[31]}}, lv_q}) - $signed({2'b00, quo_q})
                : $signed({{11{lv_q[31]}}, lv_q}) + $signed({2'b00, quo_q});
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bes_pkg::S_IDLE: begin
        if (start) begin
          case (item_i.cmd)
            bes_pkg::CMD_START: state_d = bes_pkg::S_DONE;
            bes_pkg::CMD_TICK:  state_d = bes_pkg::S_READ;
            default:            state_d = bes_pkg::S_IDLE;
          endcase
        end
      end
      bes_pkg::S_READ: state_d = (!started_q || !more_q) ? bes_pkg::S_DONE
                                                         : bes_pkg::S_MUL;
      bes_pkg::S_MUL:  state_d = bes_pkg::S_MUL2;
      bes_pkg::S_MUL2: state_d = bes_pkg::S_DIV;
      bes_pkg::S_DIV:  state_d = (cnt_q == 7'(bes_pkg::DivSteps - 1)) ? bes_pkg::S_DONE
                                                                      : bes_pkg::S_DIV;
      bes_pkg::S_DONE: state_d = bes_pkg::S_IDLE;
      default:         state_d = bes_pkg::S_IDLE;
    endcase
  end

  // result and stream update
  always_comb begin
    rv_d      = 1'b0;
    res_d     = '0;
    pos_d     = pos_q;
    left_d    = left_q;
    more_d    = more_q;
    started_d = started_q;
    if (state_q == bes_pkg::S_DONE) begin
      rv_d = 1'b1;
      if (item_q.cmd == bes_pkg::CMD_START) begin
        if (eff_cnt < 7'd2) begin
          started_d = 1'b0; more_d = 1'b0;
          res_d.status = bes_pkg::ST_START_NG;
        end else begin
          pos_d = '0; left_d = '0; more_d = 1'b1; started_d = 1'b1;
          res_d.status = bes_pkg::ST_START_OK;
        end
      end else if (!started_q) begin
        res_d.status = bes_pkg::ST_NO_START;
      end else if (!more_q) begin
        res_d.sample_value = rv_q;
        res_d.finished     = 1'b1;
        res_d.status       = bes_pkg::ST_SAMPLE;
      end else begin
        res_d.status = bes_pkg::ST_SAMPLE;
        if (wzero_q) res_d.sample_value = rv_q;
        else if (zero_q) res_d.sample_value = lv_q;
        else if (sum > 43'sd2147483647) res_d.sample_value = 32'h7fffffff;
        else if (sum < -43'sd2147483648) res_d.sample_value = 32'h80000000;
        else res_d.sample_value = sum[31:0];
        pos_d = next_pos[48] ? '1 : next_pos[47:0];
        if (pos_d > rt_q) begin
          if ({1'b0, left_q} + 7'd2 < eff_cnt) left_d = left_q + 6'd1;
          else more_d = 1'b0;
        end
      end
    end
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= bes_pkg::S_IDLE;
      time_step_q   <= bes_pkg::TimeStepReset;
      point_count_q <= '0;
      pos_q         <= '0;
      left_q        <= '0;
      more_q        <= 1'b0;
      started_q     <= 1'b0;
      res_v_q       <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      left_q    <= left_d;
      more_q    <= more_d;
      started_q <= started_d;
      res_v_q   <= rv_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == bes_pkg::CFG_TIME_STEP) time_step_q <= cfg_data_i;
        else point_count_q <= cfg_data_i[6:0];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (start && !busy) item_q <= item_i;
    case (state_q)
      bes_pkg::S_MUL: begin
        prod_q  <= {17'd0, mul_lo};
        den_q   <= wmag;
        rem_q   <= '0;
        quo_q   <= '0;
        cnt_q   <= '0;
        neg_q   <= (height_s[33] != diff_s[49]) != width_s[49];
        zero_q  <= (hmag == 32'd0) || (dmag == 49'd0);
        wzero_q <= (wmag == 49'd0);
      end
      bes_pkg::S_MUL2: begin
        prod_q <= prod_q + {mul_hi, 32'd0};
      end
      bes_pkg::S_DIV: begin
        prod_q <= {prod_q[bes_pkg::DivSteps-2:0], 1'b0};
        rem_q  <= ge ? 49'(rem_sh - {1'b0, den_q}) : rem_sh[48:0];
        cnt_q  <= cnt_q + 7'd1;
        if (quo_q[bes_pkg::QW-1]) quo_q <= quo_q;
        else quo_q <= {quo_q[bes_pkg::QW-2:0], ge};
      end
      default: ;
    endcase
  end

  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

  // checks
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !busy) else $error("cfg while busy");
  a_res_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result held");
  a_done_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bes_pkg::S_DONE |=> result_valid_o) else $error("lost result");
  a_more_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    more_q |-> started_q) else $error("more without start");

endmodule

// ===== test/breakpoint_envelope_stream_unit_tb.sv =====
`timescale 1ns / 1ps

module breakpoint_envelope_stream_unit_tb;

  localparam logic [47:0] TimeMax = 48'hFFFF_FFFF_FFFF;
  localparam longint unsigned QuotCap = 64'd1 << 40;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  bes_pkg::in_item_t  item_i = '0;
  logic               result_valid_o;
  bes_pkg::out_item_t result_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i = 1'b0;
  logic [47:0]        cfg_data_i = '0;

  breakpoint_envelope_stream_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // item traffic and expected samples
  bes_pkg::in_item_t  pending_q[$];
  bes_pkg::out_item_t sample_q[$];
  int        mismatches = 0;
  int        gap = 0;
  bit        calm = 1'b0;
  int        n_items = 0, n_ticks = 0, n_fin = 0, n_starts = 0;

  // envelope state mirror
  logic [47:0]        step_r = bes_pkg::TimeStepReset;
  logic [6:0]         count_r = '0;
  logic [47:0]        pt_time[bes_pkg::MaxPoints];
  logic signed [31:0] pt_val[bes_pkg::MaxPoints];
  logic [47:0]        pos = '0;
  int                 left = 0;
  bit                 more = 1'b0;
  bit                 running = 1'b0;

  function automatic int active_points();
    return (count_r > bes_pkg::MaxPoints) ? bes_pkg::MaxPoints : int'(count_r);
  endfunction

  function automatic int clip_slot(int i);
    return (i < bes_pkg::MaxPoints) ? i : bes_pkg::MaxPoints - 1;
  endfunction

  // linear interpolation across the current span, truncated and saturated
  function automatic logic signed [31:0] span_value();
    int l, r;
    longint lt, rt, lv, rv, w, d, h, res;
    longint unsigned ha, da, wa, q;
    logic [127:0] prod;
    bit neg;
    l  = clip_slot(left);
    r  = clip_slot(left + 1);
    lt = longint'(pt_time[l]);
    rt = longint'(pt_time[r]);
    lv = longint'(pt_val[l]);
    rv = longint'(pt_val[r]);
    w  = rt - lt;
    d  = longint'(pos) - lt;
    h  = rv - lv;
    if (w == 0) return pt_val[r];
    neg  = ((h < 0) != (d < 0)) != (w < 0);
    ha   = (h < 0) ? -h : h;
    da   = (d < 0) ? -d : d;
    wa   = (w < 0) ? -w : w;
    prod = 128'(ha) * 128'(da);
    prod = prod / 128'(wa);
    q    = (prod > 128'(QuotCap)) ? QuotCap : longint'(prod[63:0]);
    if (h == 0 || d == 0) q = 0;
    res = neg ? lv - longint'(q) : lv + longint'(q);
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res[31:0];
  endfunction

  // advance the mirror by one accepted item, queue its result if any
  task automatic envelope_step(input bes_pkg::in_item_t it);
    bes_pkg::out_item_t o;
    longint unsigned np;
    o = '0;
    n_items++;
    case (bes_pkg::cmd_e'(it.cmd))
      bes_pkg::CMD_WRITE: begin
        pt_time[it.point_index] = it.point_time;
        pt_val[it.point_index]  = it.point_value;
        return;
      end
      bes_pkg::CMD_NONE: return;
      bes_pkg::CMD_START: begin
        n_starts++;
        if (active_points() < 2) begin
          running = 1'b0;
          more    = 1'b0;
          o.status = bes_pkg::ST_START_NG;
        end else begin
          pos = '0; left = 0; more = 1'b1; running = 1'b1;
          o.status = bes_pkg::ST_START_OK;
        end
      end
      default: begin
        if (!running) begin
          o.status = bes_pkg::ST_NO_START;
        end else if (!more) begin
          o.sample_value = pt_val[clip_slot(left + 1)];
          o.finished = 1'b1;
          o.status = bes_pkg::ST_SAMPLE;
          n_fin++;
        end else begin
          n_ticks++;
          o.sample_value = span_value();
          o.status = bes_pkg::ST_SAMPLE;
          np = 64'(pos) + 64'(step_r);
          pos = (np > 64'(TimeMax)) ? TimeMax : np[47:0];
          if (pos > pt_time[clip_slot(left + 1)]) begin
            if (left + 2 < active_points()) left++;
            else more = 1'b0;
          end
        end
      end
    endcase
    sample_q.push_back(o);
  endtask

  // driver: command items with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      gap   <= 0;
    end else if (!(start && busy)) begin
      if (start) envelope_step(item_i);
      if (gap != 0) begin
        gap   <= gap - 1;
        start <= 1'b0;
      end else if (pending_q.size() != 0) begin
        if (!calm && $urandom_range(0, 5) == 0) begin
          gap   <= $urandom_range(1, 18);
          start <= 1'b0;
        end else begin
          item_i <= pending_q.pop_front();
          start  <= 1'b1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: one-cycle result strobes against the expected samples
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (sample_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result_o);
      end else begin
        bes_pkg::out_item_t e;
        e = sample_q.pop_front();
        if (result_o.sample_value !== e.sample_value || result_o.finished !== e.finished ||
            result_o.status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected val=%0d fin=%0b st=%0d, got val=%0d fin=%0b st=%0d",
                     e.sample_value, e.finished, e.status,
                     result_o.sample_value, result_o.finished, result_o.status);
        end
      end
    end
  end

  function automatic bes_pkg::in_item_t make_item(bes_pkg::cmd_e c, logic [5:0] idx,
                                                  logic [47:0] t, logic [31:0] v);
    bes_pkg::in_item_t it;
    it.cmd = c;
    it.point_index = idx;
    it.point_time = t;
    it.point_value = v;
    return it;
  endfunction

  function automatic bes_pkg::in_item_t noise_item(bes_pkg::cmd_e c);
    return make_item(c, 6'($urandom), {16'($urandom), 32'($urandom)}, $urandom);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // wait until the block has gone quiet
  task automatic settle();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || start || gap != 0 || sample_q.size() != 0);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic reg_write(bes_pkg::cfg_e idx, logic [47:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == bes_pkg::CFG_TIME_STEP) step_r = data;
    else count_r = data[6:0];
  endtask

  // one stream: load n points, start, tick through the spans
  task automatic run_stream(logic [47:0] stp, logic [6:0] cnt, bit broken);
    int n, ticks;
    longint unsigned t;
    settle();
    reg_write(bes_pkg::CFG_TIME_STEP, stp);
    reg_write(bes_pkg::CFG_POINT_COUNT, cnt);
    n = (cnt > bes_pkg::MaxPoints) ? bes_pkg::MaxPoints : int'(cnt);
    t = 0;
    for (int i = 0; i < n; i++) begin
      if (broken && $urandom_range(0, 2) == 0) t = {16'($urandom), 32'($urandom)};
      else if (i != 0)
        t += longint'($urandom_range(0, (n > 16) ? 1 : 4)) * stp
             + $urandom_range(0, 3) * (stp / 2);
      if (t > 64'(TimeMax)) t = TimeMax;
      pending_q.push_back(make_item(bes_pkg::CMD_WRITE, 6'(i), t[47:0], pick_value()));
    end
    pending_q.push_back(noise_item(bes_pkg::CMD_START));
    ticks = (n > 16) ? 2 * n + 3 : 5 * n + 4;
    for (int k = 0; k < ticks; k++) begin
      if ($urandom_range(0, 15) == 0) pending_q.push_back(noise_item(bes_pkg::CMD_NONE));
      pending_q.push_back(noise_item(bes_pkg::CMD_TICK));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the whole table so no slot is ever read unwritten
    for (int i = 0; i < bes_pkg::MaxPoints; i++)
      pending_q.push_back(make_item(bes_pkg::CMD_WRITE, 6'(i), 48'(i) << 20, pick_value()));

    // directed: ticks before start, failing starts, idle command, extremes
    pending_q.push_back(noise_item(bes_pkg::CMD_TICK));
    pending_q.push_back(noise_item(bes_pkg::CMD_START));
    pending_q.push_back(noise_item(bes_pkg::CMD_NONE));
    pending_q.push_back(noise_item(bes_pkg::CMD_TICK));
    settle();
    reg_write(bes_pkg::CFG_POINT_COUNT, 7'd1);
    pending_q.push_back(noise_item(bes_pkg::CMD_START));
    pending_q.push_back(noise_item(bes_pkg::CMD_TICK));
    settle();
    reg_write(bes_pkg::CFG_POINT_COUNT, 7'd4);
    pending_q.push_back(make_item(bes_pkg::CMD_WRITE, 6'd0, 48'd0, 32'h8000_0000));
    pending_q.push_back(make_item(bes_pkg::CMD_WRITE, 6'd1, 48'd0, 32'h7FFF_FFFF));
    pending_q.push_back(make_item(bes_pkg::CMD_WRITE, 6'd2, 48'd3, 32'h7FFF_FFFF));
    pending_q.push_back(make_item(bes_pkg::CMD_WRITE, 6'd3, TimeMax, 32'h8000_0000));
    pending_q.push_back(noise_item(bes_pkg::CMD_START));
    for (int k = 0; k < 8; k++) pending_q.push_back(noise_item(bes_pkg::CMD_TICK));
    settle();
    reg_write(bes_pkg::CFG_TIME_STEP, TimeMax);
    pending_q.push_back(noise_item(bes_pkg::CMD_START));
    for (int k = 0; k < 6; k++) pending_q.push_back(noise_item(bes_pkg::CMD_TICK));

    // random streams
    run_stream(48'd1, 7'd3, 1'b0);
    run_stream(48'd1 << 24, 7'd64, 1'b0);
    run_stream(48'd1 << 20, 7'd127, 1'b1);
    while (n_items + pending_q.size() < 800) begin
      logic [47:0] stp;
      logic [6:0] cnt;
      case ($urandom_range(0, 5))
        0: stp = 48'd1;
        1: stp = TimeMax;
        default: stp = 48'($urandom_range(1 << 10, 1 << 30));
      endcase
      cnt = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 1)) : 7'($urandom_range(2, 8));
      run_stream(stp, cnt, $urandom_range(0, 7) == 0);
      // lower the count in the middle of a stream now and then
      if ($urandom_range(0, 3) == 0) begin
        settle();
        reg_write(bes_pkg::CFG_POINT_COUNT, 7'd2);
        for (int k = 0; k < 4; k++) pending_q.push_back(noise_item(bes_pkg::CMD_TICK));
      end
    end

    // closing stream without idle gaps
    settle();
    calm = 1'b1;
    run_stream(48'd1 << 16, 7'd5, 1'b0);
    settle();
    repeat (200) @(posedge clk_i);

    $display("run: %0d items, %0d starts, %0d interpolated and %0d held samples",
             n_items, n_starts, n_ticks, n_fin);
    $display("%0d mismatches, %0d results never seen", mismatches, sample_q.size());
    if (mismatches == 0 && sample_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bes_pkg.sv
hw/rtl/breakpoint_envelope_stream_unit.sv
test/breakpoint_envelope_stream_unit_tb.sv
